/* sv/msslr_pkg.sv */
package msslr_pkg;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_LOAD  = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   localparam int IDX_W  = 15;
   localparam int FRAC_W = 16;
   localparam int SMP_W  = 16;

   typedef struct packed {
      op_type                    op;
      logic signed [SMP_W-1:0]   sample;
      logic                      neg;
      logic [IDX_W-1:0]          idx;
      logic [FRAC_W-1:0]         frac;
   } item_type;

endpackage

/* sv/msslr_ram.sv */
module msslr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/msslr_front.sv */
module msslr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_type,
   input  logic signed [15:0]  req_sample_in,
   input  logic signed [31:0]  req_position,
   output logic                item_valid,
   input  logic                item_ready,
   output msslr_pkg::item_type item
);

   msslr_pkg::item_type q_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          cnt_ff, cnt_in;
   msslr_pkg::item_type cls;
   logic                push, pop;

   always_comb begin
      case (req_type)
         2'd0:    cls.op = msslr_pkg::OP_START;
         2'd1:    cls.op = msslr_pkg::OP_LOAD;
         2'd2:    cls.op = msslr_pkg::OP_READ;
         default: cls.op = msslr_pkg::OP_NOP;
      endcase
      cls.sample = req_sample_in;
      cls.neg    = req_position[31];
      cls.idx    = req_position[30:16];
      cls.frac   = req_position[15:0];
   end

   assign busy       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign push       = start && !busy;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* sv/msslr_div.sv */
module msslr_div #(
   parameter int SW  = 19,
   parameter int CNW = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 div_start,
   input  logic signed [SW-1:0] dividend,
   input  logic [CNW-1:0]       divisor,
   output logic                 done,
   output logic signed [SW-1:0] quotient
);

   localparam int STW = $clog2(SW + 1);

   logic [SW-1:0]  q_ff, q_in;
   logic [CNW-1:0] rem_ff, rem_in;
   logic [CNW-1:0] div_ff, div_in;
   logic           neg_ff, neg_in;
   logic [STW-1:0] step_ff, step_in;
   logic           run_ff, run_in;
   logic           done_ff, done_in;
   logic [CNW:0]   shl;
   logic           ge;

   assign shl = {rem_ff, q_ff[SW-1]};
   assign ge  = (shl >= {1'b0, div_ff});

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_start) begin
         neg_in  = dividend[SW-1];
         q_in    = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
         rem_in  = '0;
         div_in  = divisor;
         step_in = STW'(SW);
         run_in  = 1'b1;
      end else if (run_ff) begin
         q_in    = {q_ff[SW-2:0], ge};
         rem_in  = ge ? CNW'(shl - {1'b0, div_ff}) : CNW'(shl);
         step_in = step_ff - STW'(1);
         if (step_ff == STW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule

/* sv/msslr_back.sv */
module msslr_back #(
   parameter int STORE_DEPTH  = 65536,
   parameter int MAX_CHANNELS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   output logic                                item_ready,
   input  msslr_pkg::item_type                 item,
   input  logic [$clog2(MAX_CHANNELS+1)-1:0]   chan_eff,
   output logic                                rsp_strobe,
   output logic signed [15:0]                  rsp_sample_out,
   output logic [16:0]                         rsp_frames_held,
   output logic                                rsp_has_data,
   output logic                                rsp_overflowed
);

   localparam int CNW = $clog2(MAX_CHANNELS + 1);
   localparam int SW  = 16 + $clog2(MAX_CHANNELS);
   localparam int CW  = $clog2(STORE_DEPTH + 1);
   localparam int AW  = $clog2(STORE_DEPTH);
   localparam int KW  = (CW > 16) ? CW : 16;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_DIV     = 6'b000010,
      ST_RD_HI   = 6'b000100,
      ST_RD_DIFF = 6'b001000,
      ST_MUL     = 6'b010000,
      ST_SUM     = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         frames_ff, frames_in;
   logic [CNW-1:0]        pos_ff, pos_in;
   logic signed [SW-1:0]  sum_ff, sum_in;
   logic                  drop_ff, drop_in;
   logic [AW-1:0]         hi_ff, hi_in;
   logic [15:0]           frac_ff, frac_in;
   logic signed [15:0]    low_ff, low_in;
   logic signed [16:0]    diff_ff, diff_in;
   logic signed [15:0]    prod_ff, prod_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic signed [15:0]    rsp_sample_ff, rsp_sample_in;
   logic [16:0]           rsp_frames_ff, rsp_frames_in;
   logic                  rsp_has_ff, rsp_has_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  div_start, div_done;
   logic signed [SW-1:0]  acc, quot;
   logic [CNW-1:0]        cnt_next;
   logic [KW-1:0]         idx_k, idx_k1, frames_k;
   logic signed [15:0]    sat;
   logic                  wr_en;
   logic [AW-1:0]         rd_addr;
   logic [15:0]           rd_data;
   logic signed [33:0]    mult_full;

   msslr_div #(
      .SW  (SW),
      .CNW (CNW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (acc),
      .divisor   (chan_eff),
      .done      (div_done),
      .quotient  (quot)
   );

   msslr_ram #(
      .WIDTH (16),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(frames_ff)),
      .wr_data (sat),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign acc       = sum_ff + SW'($signed(item.sample));
   assign cnt_next  = pos_ff + CNW'(1);
   assign idx_k     = KW'(item.idx);
   assign idx_k1    = idx_k + KW'(1);
   assign frames_k  = KW'(frames_ff);
   assign mult_full = diff_ff * $signed({1'b0, frac_ff});

   always_comb begin
      if (quot > 32'sd32767) begin
         sat = 16'sh7fff;
      end else if (quot < -32'sd32768) begin
         sat = -16'sh8000;
      end else begin
         sat = 16'(quot);
      end
   end

   always_comb begin
      state_in      = state_ff;
      frames_in     = frames_ff;
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      drop_in       = drop_ff;
      hi_in         = hi_ff;
      frac_in       = frac_ff;
      low_in        = low_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      rsp_strobe_in = 1'b0;
      rsp_sample_in = '0;
      div_start     = 1'b0;
      wr_en         = 1'b0;
      rd_addr       = '0;
      item_ready    = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               case (item.op)
                  msslr_pkg::OP_START: begin
                     frames_in     = '0;
                     pos_in        = '0;
                     sum_in        = '0;
                     drop_in       = 1'b0;
                     rsp_strobe_in = 1'b1;
                  end
                  msslr_pkg::OP_LOAD: begin
                     if (cnt_next >= chan_eff) begin
                        div_start = 1'b1;
                        pos_in    = '0;
                        sum_in    = '0;
                        state_in  = ST_DIV;
                     end else begin
                        pos_in        = cnt_next;
                        sum_in        = acc;
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  msslr_pkg::OP_READ: begin
                     if (frames_ff == '0 || item.neg || idx_k >= frames_k) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        rd_addr  = AW'(idx_k);
                        hi_in    = (idx_k1 == frames_k) ? AW'(idx_k) : AW'(idx_k1);
                        frac_in  = item.frac;
                        state_in = ST_RD_HI;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (frames_ff != CW'(STORE_DEPTH)) begin
                  wr_en     = 1'b1;
                  frames_in = frames_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_RD_HI: begin
            rd_addr  = hi_ff;
            low_in   = $signed(rd_data);
            state_in = ST_RD_DIFF;
         end
         ST_RD_DIFF: begin
            diff_in  = 17'($signed(rd_data)) - 17'(low_ff);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = mult_full[31:16];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rsp_sample_in = low_ff + prod_ff;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_frames_in = 17'(frames_in);
      rsp_has_in    = (frames_in != '0);
      rsp_ovf_in    = drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         frames_ff     <= '0;
         pos_ff        <= '0;
         sum_ff        <= '0;
         drop_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frames_ff     <= frames_in;
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         drop_ff       <= drop_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff         <= hi_in;
      frac_ff       <= frac_in;
      low_ff        <= low_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_frames_held = rsp_frames_ff;
   assign rsp_has_data    = rsp_has_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

endmodule

/* sv/mono_sample_store_lerp_read.sv */
// Start, other and mid-frame load words are answered from the idle state; a frame-closing
//   load waits on the serial divider; a read that hits makes two reads on the one RAM
//   read port, then a multiply and add.
// Throughput: one word in flight in the back end, 2-entry queue in front;
//   busy rises only when the queue is full. rsp_strobe is never held off.
// Reset clears counters, flags and queue; sample RAM contents are not cleared.
module mono_sample_store_lerp_read #(
   parameter int STORE_DEPTH  = 65536,
   parameter int MAX_CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic signed [15:0] req_sample_in,
   input  logic signed [31:0] req_position,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_sample_out,
   output logic [16:0]        rsp_frames_held,
   output logic               rsp_has_data,
   output logic               rsp_overflowed,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_channel_count
);

   localparam int CNW = $clog2(MAX_CHANNELS + 1);

   logic [3:0]          chan_ff, chan_in;
   logic [CNW-1:0]      chan_eff;
   logic                item_valid, item_ready;
   msslr_pkg::item_type item;

   assign csr_ready = 1'b1;
   assign chan_in   = (csr_valid && csr_ready) ? csr_channel_count : chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= 4'd1;
      end else begin
         chan_ff <= chan_in;
      end
   end

   always_comb begin
      if (chan_ff == 4'd0) begin
         chan_eff = CNW'(1);
      end else if ({28'd0, chan_ff} > 32'(MAX_CHANNELS)) begin
         chan_eff = CNW'(MAX_CHANNELS);
      end else begin
         chan_eff = CNW'(chan_ff);
      end
   end

   msslr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_sample_in (req_sample_in),
      .req_position  (req_position),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item)
   );

   msslr_back #(
      .STORE_DEPTH  (STORE_DEPTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item),
      .chan_eff        (chan_eff),
      .rsp_strobe      (rsp_strobe),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_frames_held (rsp_frames_held),
      .rsp_has_data    (rsp_has_data),
      .rsp_overflowed  (rsp_overflowed)
   );

endmodule
